>>> hdl/ntour_pkg.sv
// Package for the nearest-neighbor tour block: sizes, opcodes, sequencer states
// and the structs passed between the sequencer and the distance pipeline.
// No dependencies.
package ntour_pkg;

   localparam int MAX_POINTS       = 64;
   localparam int COORD_BITS       = 16;
   localparam int IDX_BITS         = $clog2(MAX_POINTS);
   localparam int FIELD_IDX_BITS   = 6;
   localparam int FIELD_COORD_BITS = 16;
   localparam int CNT_BITS         = 7;
   localparam int LEN_BITS         = 31;
   localparam int FRAC_BITS        = 8;
   localparam int SUM_W            = 2 * COORD_BITS + 1;
   localparam int RAD_W            = ((SUM_W + 2 * FRAC_BITS + 1) / 2) * 2;
   localparam int ROOT_W           = RAD_W / 2;
   localparam int REM_W            = ROOT_W + 2;

   localparam logic [CNT_BITS-1:0] PCOUNT_RESET = 7'd64;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_RUN  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LATCH,
      ST_EMIT,
      ST_SCAN,
      ST_DRAIN,
      ST_PICK
   } seq_state_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
   } point_type;

   typedef struct packed {
      logic                  valid;
      logic [IDX_BITS-1:0]   idx;
      logic [COORD_BITS-1:0] cur_x;
      logic [COORD_BITS-1:0] cur_y;
   } dist_req_type;

   typedef struct packed {
      logic                valid;
      logic [IDX_BITS-1:0] idx;
      logic [ROOT_W-1:0]   root;
   } dist_rsp_type;

endpackage

>>> hdl/ntour_ifs.sv
// Valid/ready channel interfaces for the request (load/run) and response (tour city) beats.
// Depends on ntour_pkg.
interface ntour_req_if import ntour_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic                        opcode;
   logic [FIELD_IDX_BITS-1:0]   point_index;
   logic [FIELD_COORD_BITS-1:0] point_x;
   logic [FIELD_COORD_BITS-1:0] point_y;

   modport source (output valid, opcode, point_index, point_x, point_y, input ready);
   modport sink   (input valid, opcode, point_index, point_x, point_y, output ready);
endinterface

interface ntour_rsp_if import ntour_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [FIELD_IDX_BITS-1:0] tour_position;
   logic [FIELD_IDX_BITS-1:0] city_index;
   logic                      last_city;
   logic [LEN_BITS-1:0]       tour_length;

   modport source (output valid, tour_position, city_index, last_city, tour_length,
                   input ready);
   modport sink   (input valid, tour_position, city_index, last_city, tour_length,
                   output ready);
endinterface

>>> hdl/ntour_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module ntour_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/ntour_dist.sv
// Distance pipeline: |dx|,|dy|, squares, sum, then one root bit per stage of
// floor(256*sqrt(dx^2+dy^2)). Accepts one candidate per cycle. Depends on ntour_pkg.
module ntour_dist import ntour_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  dist_req_type issue,
   input  point_type    rdata,
   output dist_rsp_type result,
   output logic         busy
);

   logic                    tag_v_ff;
   logic [IDX_BITS-1:0]     tag_idx_ff;
   logic                    v1_ff, v2_ff, v3_ff;
   logic [IDX_BITS-1:0]     idx1_ff, idx2_ff, idx3_ff;
   logic [COORD_BITS-1:0]   dx_ff, dy_ff;
   logic [COORD_BITS-1:0]   dx_in, dy_in;
   logic [2*COORD_BITS-1:0] dx2_ff, dy2_ff;
   logic [SUM_W-1:0]        sum_ff;

   logic [ROOT_W-1:0]   sq_v_ff;
   logic [IDX_BITS-1:0] sq_idx_ff  [ROOT_W];
   logic [RAD_W-1:0]    sq_rad_ff  [ROOT_W];
   logic [REM_W-1:0]    sq_rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]   sq_root_ff [ROOT_W];

   logic [RAD_W-1:0]  in_rad  [ROOT_W];
   logic [REM_W-1:0]  in_rem  [ROOT_W];
   logic [ROOT_W-1:0] in_root [ROOT_W];
   logic [REM_W-1:0]  rem_sh  [ROOT_W];
   logic [REM_W-1:0]  trial   [ROOT_W];
   logic [ROOT_W-1:0] ge;
   logic [RAD_W-1:0]  sq_rad_in  [ROOT_W];
   logic [REM_W-1:0]  sq_rem_in  [ROOT_W];
   logic [ROOT_W-1:0] sq_root_in [ROOT_W];

   always_comb begin
      dx_in = (rdata.x > issue.cur_x) ? rdata.x - issue.cur_x : issue.cur_x - rdata.x;
      dy_in = (rdata.y > issue.cur_y) ? rdata.y - issue.cur_y : issue.cur_y - rdata.y;
   end

   // one restoring square-root step per stage
   always_comb begin
      for (int k = 0; k < ROOT_W; k++) begin
         if (k == 0) begin
            in_rad[k]  = RAD_W'({sum_ff, {(2 * FRAC_BITS){1'b0}}});
            in_rem[k]  = '0;
            in_root[k] = '0;
         end else begin
            in_rad[k]  = sq_rad_ff[k-1];
            in_rem[k]  = sq_rem_ff[k-1];
            in_root[k] = sq_root_ff[k-1];
         end
         rem_sh[k]     = {in_rem[k][REM_W-3:0], in_rad[k][RAD_W-1 -: 2]};
         trial[k]      = {in_root[k], 2'b01};
         ge[k]         = (rem_sh[k] >= trial[k]);
         sq_rem_in[k]  = ge[k] ? rem_sh[k] - trial[k] : rem_sh[k];
         sq_root_in[k] = {in_root[k][ROOT_W-2:0], ge[k]};
         sq_rad_in[k]  = in_rad[k] << 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_v_ff <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         sq_v_ff  <= '0;
      end else begin
         tag_v_ff <= issue.valid;
         v1_ff    <= tag_v_ff;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         sq_v_ff  <= {sq_v_ff[ROOT_W-2:0], v3_ff};
      end
   end

   always_ff @(posedge clock) begin
      tag_idx_ff <= issue.idx;
      idx1_ff    <= tag_idx_ff;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      idx2_ff    <= idx1_ff;
      dx2_ff     <= (2 * COORD_BITS)'(dx_ff) * (2 * COORD_BITS)'(dx_ff);
      dy2_ff     <= (2 * COORD_BITS)'(dy_ff) * (2 * COORD_BITS)'(dy_ff);
      idx3_ff    <= idx2_ff;
      sum_ff     <= SUM_W'(dx2_ff) + SUM_W'(dy2_ff);
      for (int k = 0; k < ROOT_W; k++) begin
         sq_idx_ff[k]  <= (k == 0) ? idx3_ff : sq_idx_ff[k-1];
         sq_rad_ff[k]  <= sq_rad_in[k];
         sq_rem_ff[k]  <= sq_rem_in[k];
         sq_root_ff[k] <= sq_root_in[k];
      end
   end

   assign result.valid = sq_v_ff[ROOT_W-1];
   assign result.idx   = sq_idx_ff[ROOT_W-1];
   assign result.root  = sq_root_ff[ROOT_W-1];
   assign busy         = tag_v_ff | v1_ff | v2_ff | v3_ff | (|sq_v_ff);

endmodule

>>> hdl/ntour_seq.sv
// Tour sequencer: point loads, visited map, nearest-candidate selection, length
// accumulation and the response output register. Depends on ntour_pkg, ntour_ifs.
module ntour_seq import ntour_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ntour_req_if.sink             req_bus,
   ntour_rsp_if.source           rsp_bus,
   input  logic                  csr_wr_en,
   input  logic [CNT_BITS-1:0]   csr_wr_data,
   output logic                  ram_we,
   output logic [IDX_BITS-1:0]   ram_waddr,
   output point_type             ram_wdata,
   output logic [IDX_BITS-1:0]   ram_raddr,
   input  point_type             ram_rdata,
   output dist_req_type          issue,
   input  dist_rsp_type          dist_out,
   input  logic                  dist_busy
);

   seq_state_type state_ff, state_in;
   logic [CNT_BITS-1:0]   point_count_ff, point_count_in;
   logic [CNT_BITS-1:0]   cnt_clip;
   logic [MAX_POINTS-1:0] visited_ff, visited_in;
   logic [IDX_BITS-1:0]   cur_ff, cur_in;
   logic [LEN_BITS-1:0]   length_ff, length_in;
   logic                  closing_ff, closing_in;
   logic                  found_ff, found_in;
   logic [IDX_BITS-1:0]   pos_ff, pos_in;
   logic [IDX_BITS-1:0]   last_pos_ff, last_pos_in;
   logic [IDX_BITS-1:0]   scan_idx_ff, scan_idx_in;
   logic [COORD_BITS-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [ROOT_W-1:0]     best_root_ff, best_root_in;
   logic [IDX_BITS-1:0]   best_idx_ff, best_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FIELD_IDX_BITS-1:0] rsp_pos_ff, rsp_pos_in, rsp_city_ff, rsp_city_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [LEN_BITS-1:0]   rsp_len_ff, rsp_len_in;
   logic                  out_free;

   always_comb begin
      if (point_count_ff == '0) begin
         cnt_clip = CNT_BITS'(1);
      end else if (point_count_ff > CNT_BITS'(MAX_POINTS)) begin
         cnt_clip = CNT_BITS'(MAX_POINTS);
      end else begin
         cnt_clip = point_count_ff;
      end
   end

   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      point_count_in = csr_wr_en ? csr_wr_data : point_count_ff;
      visited_in     = visited_ff;
      cur_in         = cur_ff;
      length_in      = length_ff;
      closing_in     = closing_ff;
      found_in       = found_ff;
      pos_in         = pos_ff;
      last_pos_in    = last_pos_ff;
      scan_idx_in    = scan_idx_ff;
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      best_root_in   = best_root_ff;
      best_idx_in    = best_idx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_pos_in     = rsp_pos_ff;
      rsp_city_in    = rsp_city_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_len_in     = rsp_len_ff;
      ram_we         = 1'b0;
      ram_waddr      = req_bus.point_index[IDX_BITS-1:0];
      ram_wdata.x    = req_bus.point_x[COORD_BITS-1:0];
      ram_wdata.y    = req_bus.point_y[COORD_BITS-1:0];
      ram_raddr      = scan_idx_ff;
      issue.valid    = 1'b0;
      issue.idx      = scan_idx_ff;
      issue.cur_x    = cur_x_ff;
      issue.cur_y    = cur_y_ff;

      // strict less-than on the truncated distance keeps the lowest index
      if (dist_out.valid && (closing_ff || !visited_ff[dist_out.idx]) &&
          (!found_ff || dist_out.root[ROOT_W-1:FRAC_BITS] <
                        best_root_ff[ROOT_W-1:FRAC_BITS])) begin
         found_in     = 1'b1;
         best_root_in = dist_out.root;
         best_idx_in  = dist_out.idx;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               if (req_bus.opcode == OP_LOAD) begin
                  ram_we = (int'(req_bus.point_index) < MAX_POINTS);
               end else begin
                  visited_in  = MAX_POINTS'(1);
                  cur_in      = '0;
                  length_in   = '0;
                  pos_in      = '0;
                  closing_in  = 1'b0;
                  last_pos_in = IDX_BITS'(cnt_clip - CNT_BITS'(1));
                  state_in    = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            ram_raddr = cur_ff;
            state_in  = ST_LATCH;
         end
         ST_LATCH: begin
            cur_x_in = ram_rdata.x;
            cur_y_in = ram_rdata.y;
            if (pos_ff == last_pos_ff) begin
               // closing edge back to point 0
               closing_in  = 1'b1;
               scan_idx_in = '0;
               found_in    = 1'b0;
               state_in    = ST_SCAN;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = FIELD_IDX_BITS'(pos_ff);
               rsp_city_in  = FIELD_IDX_BITS'(cur_ff);
               rsp_last_in  = closing_ff;
               rsp_len_in   = closing_ff ? length_ff : '0;
               scan_idx_in  = '0;
               found_in     = 1'b0;
               state_in     = closing_ff ? ST_IDLE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            issue.valid = 1'b1;
            if (closing_ff || scan_idx_ff == last_pos_ff) begin
               state_in = ST_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + IDX_BITS'(1);
            end
         end
         ST_DRAIN: begin
            if (!dist_busy) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            length_in = length_ff + LEN_BITS'(best_root_ff);
            if (closing_ff) begin
               state_in = ST_EMIT;
            end else begin
               pos_in                  = pos_ff + IDX_BITS'(1);
               cur_in                  = best_idx_ff;
               visited_in[best_idx_ff] = 1'b1;
               state_in                = ST_FETCH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         point_count_ff <= PCOUNT_RESET;
         visited_ff     <= '0;
         cur_ff         <= '0;
         length_ff      <= '0;
         closing_ff     <= 1'b0;
         found_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         point_count_ff <= point_count_in;
         visited_ff     <= visited_in;
         cur_ff         <= cur_in;
         length_ff      <= length_in;
         closing_ff     <= closing_in;
         found_ff       <= found_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      last_pos_ff  <= last_pos_in;
      scan_idx_ff  <= scan_idx_in;
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      best_root_ff <= best_root_in;
      best_idx_ff  <= best_idx_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_city_ff  <= rsp_city_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_len_ff   <= rsp_len_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.tour_position = rsp_pos_ff;
   assign rsp_bus.city_index    = rsp_city_ff;
   assign rsp_bus.last_city     = rsp_last_ff;
   assign rsp_bus.tour_length   = rsp_len_ff;

endmodule

>>> hdl/nearest_neighbour_tour.sv
// Top level of the nearest-neighbor tour block: point store RAM, distance pipeline
// and sequencer. Depends on ntour_pkg, ntour_ifs, ntour_ram, ntour_dist, ntour_seq.
//
//   port       dir   beat
//   req_bus    in    load one point (opcode 0) or run a tour (opcode 1)
//   rsp_bus    out   one city per tour position; last beat carries tour length
//   csr_wr_*   in    point_count register write
//
// Run with n points: n response beats. Each step streams all n slots (the closing
// step only slot 0) through the single store read port into the 29-stage
// distance/root pipeline, then drains it before picking.
// Reset clears the visited map and control; the store is not cleared.
// req_bus is ready only when no run is in progress; a stalled rsp_bus holds the
// sequencer at the pending beat.
module nearest_neighbour_tour import ntour_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   ntour_req_if.sink           req_bus,
   ntour_rsp_if.source         rsp_bus,
   input  logic                csr_wr_en,
   input  logic [CNT_BITS-1:0] csr_wr_data
);

   logic                ram_we;
   logic [IDX_BITS-1:0] ram_waddr;
   logic [IDX_BITS-1:0] ram_raddr;
   point_type           ram_wdata;
   point_type           ram_rdata;
   dist_req_type        issue;
   dist_rsp_type        dist_out;
   logic                dist_busy;

   ntour_ram #(
      .WIDTH (2 * COORD_BITS),
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   ntour_dist u_dist (
      .clock  (clock),
      .reset  (reset),
      .issue  (issue),
      .rdata  (ram_rdata),
      .result (dist_out),
      .busy   (dist_busy)
   );

   ntour_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .ram_we      (ram_we),
      .ram_waddr   (ram_waddr),
      .ram_wdata   (ram_wdata),
      .ram_raddr   (ram_raddr),
      .ram_rdata   (ram_rdata),
      .issue       (issue),
      .dist_out    (dist_out),
      .dist_busy   (dist_busy)
   );

   a_run_blocks_req: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready && req_bus.opcode == OP_RUN |=> !req_bus.ready)
      else $error("request taken during a run");

   a_len_only_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.last_city |-> rsp_bus.tour_length == '0)
      else $error("tour length on a non-final beat");

   a_mid_tour_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.last_city |-> !req_bus.ready)
      else $error("idle before the final beat");

   a_no_issue_while_idle: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready |-> !issue.valid && !dist_busy)
      else $error("distance pipeline active while idle");

endmodule

>>> tb/tb.sv
// Self-checking testbench for nearest_neighbour_tour: loads points, runs greedy tours
// and compares every city beat against an in-bench tour predictor.
// Depends on ntour_pkg, ntour_ifs and the nearest_neighbour_tour RTL.
module tb;
   import ntour_pkg::*;

   localparam int LIMIT_CYCLES = 4_000_000;
   localparam int RANDOM_ITEMS = 110;
   localparam int IDLE_CYCLES  = 16;
   localparam int DRAIN_CYCLES = 100;

   typedef struct packed {
      logic [FIELD_IDX_BITS-1:0] position;
      logic [FIELD_IDX_BITS-1:0] city;
      logic                      is_last;
      logic [LEN_BITS-1:0]       tour_len;
   } city_beat_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en;
   logic [CNT_BITS-1:0] csr_wr_data;

   ntour_req_if req_bus ();
   ntour_rsp_if rsp_bus ();

   nearest_neighbour_tour dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // predictor state
   logic [FIELD_COORD_BITS-1:0] x_pos [MAX_POINTS];
   logic [FIELD_COORD_BITS-1:0] y_pos [MAX_POINTS];
   bit                          loaded [MAX_POINTS];
   int                          tour_size = MAX_POINTS;
   city_beat_type               pending_cities [$];

   int          mismatches = 0;
   int          items_sent = 0;
   int          burst_left = 0;
   longint      cycle_count = 0;

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("%0t: timeout, %0d beats still expected", $time, pending_cities.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned r;
      longint unsigned cand;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         cand = r | (64'd1 << b);
         if (cand * cand <= v)
            r = cand;
      end
      return r;
   endfunction

   function automatic longint unsigned span_sq(input int a, input int b);
      longint unsigned dx;
      longint unsigned dy;
      dx = (x_pos[a] > x_pos[b]) ? x_pos[a] - x_pos[b] : x_pos[b] - x_pos[a];
      dy = (y_pos[a] > y_pos[b]) ? y_pos[a] - y_pos[b] : y_pos[b] - y_pos[a];
      return dx * dx + dy * dy;
   endfunction

   function automatic logic [LEN_BITS-1:0] edge_fixed(input int a, input int b);
      return LEN_BITS'(int_sqrt(span_sq(a, b) << 16));
   endfunction

   // greedy tour from point 0; pushes one beat per tour position
   function automatic void plan_tour();
      bit                  seen [MAX_POINTS];
      int                  cur;
      int                  pick;
      bit                  found;
      longint unsigned     best;
      longint unsigned     d;
      logic [LEN_BITS-1:0] total;
      city_beat_type       beat;
      foreach (seen[i]) seen[i] = 1'b0;
      seen[0] = 1'b1;
      cur     = 0;
      total   = '0;
      for (int pos = 0; pos < tour_size; pos++) begin
         if (pos > 0) begin
            found = 1'b0;
            best  = 0;
            pick  = 0;
            for (int i = 0; i < tour_size; i++) begin
               if (seen[i] || i == cur)
                  continue;
               d = int_sqrt(span_sq(cur, i));
               if (!found || d < best) begin
                  found = 1'b1;
                  best  = d;
                  pick  = i;
               end
            end
            total     = total + edge_fixed(cur, pick);
            seen[pick] = 1'b1;
            cur       = pick;
         end
         beat.position = FIELD_IDX_BITS'(pos);
         beat.city     = FIELD_IDX_BITS'(cur);
         beat.is_last  = 1'b0;
         beat.tour_len = '0;
         if (pos == tour_size - 1) begin
            total         = total + edge_fixed(cur, 0);
            beat.is_last  = 1'b1;
            beat.tour_len = total;
         end
         pending_cities.push_back(beat);
      end
   endfunction

   function automatic bit tour_points_loaded();
      for (int i = 0; i < tour_size; i++)
         if (!loaded[i])
            return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [FIELD_COORD_BITS-1:0] pick_coord(input int mode);
      case (mode)
         0: return FIELD_COORD_BITS'($urandom_range(0, 65535));
         1: return FIELD_COORD_BITS'($urandom_range(1000, 1015));
         2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: return $urandom_range(0, 1) ? FIELD_COORD_BITS'($urandom_range(0, 65535))
                                              : FIELD_COORD_BITS'($urandom_range(0, 7));
      endcase
   endfunction

   task automatic send_beat(input logic op, input logic [FIELD_IDX_BITS-1:0] idx,
                            input logic [FIELD_COORD_BITS-1:0] px,
                            input logic [FIELD_COORD_BITS-1:0] py);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid       <= 1'b1;
      req_bus.opcode      <= op;
      req_bus.point_index <= idx;
      req_bus.point_x     <= px;
      req_bus.point_y     <= py;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
      if (op == OP_LOAD) begin
         x_pos[idx]  = px;
         y_pos[idx]  = py;
         loaded[idx] = 1'b1;
      end else begin
         plan_tour();
      end
   endtask

   task automatic send_run();
      send_beat(OP_RUN, FIELD_IDX_BITS'($urandom_range(0, 63)),
                FIELD_COORD_BITS'($urandom_range(0, 65535)),
                FIELD_COORD_BITS'($urandom_range(0, 65535)));
   endtask

   // register writes only once the block has gone quiet
   task automatic write_point_count(input logic [CNT_BITS-1:0] value);
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (pending_cities.size() != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (value == 0)
         tour_size = 1;
      else if (value > MAX_POINTS)
         tour_size = MAX_POINTS;
      else
         tour_size = value;
   endtask

   task automatic fill_and_run(input int mode);
      for (int i = 0; i < tour_size; i++)
         if (!loaded[i])
            send_beat(OP_LOAD, FIELD_IDX_BITS'(i), pick_coord(mode), pick_coord(mode));
      send_run();
   endtask

   task automatic test_single_point();
      write_point_count(7'd1);
      send_beat(OP_LOAD, 6'd0, 16'd0, 16'd0);
      send_beat(OP_RUN, 6'd0, 16'd0, 16'd0);
      // zero count behaves as one point
      write_point_count(7'd0);
      send_beat(OP_RUN, 6'd63, 16'hFFFF, 16'hFFFF);
   endtask

   task automatic test_coord_extremes();
      write_point_count(7'd2);
      send_beat(OP_LOAD, 6'd1, 16'hFFFF, 16'hFFFF);
      send_run();
      send_beat(OP_LOAD, 6'd63, 16'hFFFF, 16'h0000);
      send_beat(OP_LOAD, 6'd0, 16'hFFFF, 16'h0000);
      send_beat(OP_LOAD, 6'd1, 16'h0000, 16'hFFFF);
      send_run();
   endtask

   task automatic test_tie_break();
      write_point_count(7'd5);
      send_beat(OP_LOAD, 6'd0, 16'd100, 16'd100);
      send_beat(OP_LOAD, 6'd1, 16'd103, 16'd104);
      send_beat(OP_LOAD, 6'd2, 16'd105, 16'd100);
      send_beat(OP_LOAD, 6'd3, 16'd100, 16'd100);
      send_beat(OP_LOAD, 6'd4, 16'd95, 16'd101);
      send_run();
   endtask

   task automatic test_random_tours();
      int                  start;
      int                  mode;
      int                  steps;
      logic [CNT_BITS-1:0] count;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       count = 7'd0;
            1:       count = 7'd64;
            2:       count = CNT_BITS'($urandom_range(65, 127));
            3:       count = CNT_BITS'($urandom_range(11, 40));
            default: count = CNT_BITS'($urandom_range(1, 10));
         endcase
         write_point_count(count);
         mode  = $urandom_range(0, 3);
         steps = $urandom_range(3, 12);
         repeat (steps) begin
            if ($urandom_range(0, 3) == 0 && tour_points_loaded())
               send_run();
            else if ($urandom_range(0, 2) != 0)
               send_beat(OP_LOAD, FIELD_IDX_BITS'($urandom_range(0, tour_size - 1)),
                         pick_coord(mode), pick_coord(mode));
            else
               send_beat(OP_LOAD, FIELD_IDX_BITS'($urandom_range(0, 63)),
                         pick_coord(mode), pick_coord(mode));
         end
         fill_and_run(mode);
      end
   endtask

   task automatic test_full_store();
      write_point_count(7'd64);
      fill_and_run(0);
      write_point_count(7'd127);
      send_beat(OP_LOAD, FIELD_IDX_BITS'($urandom_range(0, 63)), pick_coord(3), pick_coord(3));
      send_run();
   endtask

   // result side: stall pattern and beat checker
   initial begin : rsp_side
      int stall_mode;
      int stall_left;
      city_beat_type exp_beat;
      stall_mode = 0;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_cities.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected beat pos %0d city %0d last %0b len %0d", $time,
                        rsp_bus.tour_position, rsp_bus.city_index, rsp_bus.last_city,
                        rsp_bus.tour_length);
            end else begin
               exp_beat = pending_cities.pop_front();
               if (rsp_bus.tour_position !== exp_beat.position ||
                   rsp_bus.city_index !== exp_beat.city ||
                   rsp_bus.last_city !== exp_beat.is_last ||
                   rsp_bus.tour_length !== exp_beat.tour_len) begin
                  mismatches++;
                  $display("%0t: exp pos/city/last/len %0d/%0d/%0b/%0d, got %0d/%0d/%0b/%0d",
                           $time, exp_beat.position, exp_beat.city, exp_beat.is_last,
                           exp_beat.tour_len, rsp_bus.tour_position, rsp_bus.city_index,
                           rsp_bus.last_city, rsp_bus.tour_length);
               end
            end
         end
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
         end
         stall_left--;
         case (stall_mode)
            0:       rsp_bus.ready <= 1'b1;
            1:       rsp_bus.ready <= $urandom_range(0, 1);
            2:       rsp_bus.ready <= ($urandom_range(0, 7) != 0);
            default: rsp_bus.ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   initial begin : stimulus
      req_bus.valid       <= 1'b0;
      req_bus.opcode      <= OP_LOAD;
      req_bus.point_index <= '0;
      req_bus.point_x     <= '0;
      req_bus.point_y     <= '0;
      csr_wr_en           <= 1'b0;
      csr_wr_data         <= '0;
      foreach (loaded[i]) loaded[i] = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_point();
      test_coord_extremes();
      test_tie_break();
      test_random_tours();
      test_full_store();

      req_bus.valid <= 1'b0;
      while (pending_cities.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_cities.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> filelist.f
hdl/ntour_pkg.sv
hdl/ntour_ifs.sv
hdl/ntour_ram.sv
hdl/ntour_dist.sv
hdl/ntour_seq.sv
hdl/nearest_neighbour_tour.sv
tb/tb.sv
